// ===== design/srl_pkg.sv =====
// Shared constants, types and control codes for the stereo linear resampler.
`default_nettype none

package srl_pkg;

  // Fixed-point format of the phase and the length cap of one run.
  localparam int PHASE_FRAC_BITS = 16;
  localparam int MAX_RUN         = 8;

  // Field and register widths.
  localparam int SAMPLE_W  = 16;
  localparam int STEP_W    = 19;
  localparam int GAIN_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_DATA_W = (STEP_W > GAIN_W) ? STEP_W : GAIN_W;

  // Phase accumulator holds a value below one plus one step.
  localparam int PHASE_W = ((PHASE_FRAC_BITS > STEP_W) ? PHASE_FRAC_BITS : STEP_W) + 1;
  localparam logic [PHASE_W-1:0] PHASE_ONE = PHASE_W'(1) << PHASE_FRAC_BITS;

  // Run counter indexes results 0 .. MAX_RUN-1.
  localparam int RUN_W = (MAX_RUN > 1) ? $clog2(MAX_RUN) : 1;
  localparam logic [RUN_W-1:0] RUN_LAST = RUN_W'(MAX_RUN - 1);

  // Register reset values.
  localparam logic [STEP_W-1:0] STEP_RESET = STEP_W'(83116);
  localparam logic [GAIN_W-1:0] GAIN_RESET = GAIN_W'(256);

  // Datapath widths.
  localparam int DIFF_W  = SAMPLE_W + 1;
  localparam int IV_W    = SAMPLE_W + PHASE_FRAC_BITS + 2;
  localparam int MAG_W   = SAMPLE_W + PHASE_FRAC_BITS;
  localparam int MULA_W  = MAG_W + 1;
  localparam int MULB_A  = (DIFF_W > PHASE_FRAC_BITS + 1) ? DIFF_W : PHASE_FRAC_BITS + 1;
  localparam int MULB_W  = (MULB_A > GAIN_W + 1) ? MULB_A : GAIN_W + 1;
  localparam int PROD_W  = MULA_W + MULB_W;

  // Gained magnitude is clamped to 2^(24+F) before the final scaling.
  localparam int CAP_W = 25 + PHASE_FRAC_BITS;
  localparam logic [CAP_W-1:0] MAG_CAP = {1'b1, {(CAP_W-1){1'b0}}};

  // Scaling by 32767/32768 is (x << 15) - x followed by a right shift.
  localparam int TRIM_BITS   = 15;
  localparam int SCALED_W    = CAP_W + TRIM_BITS;
  localparam int SCALE_SHIFT = 23 + PHASE_FRAC_BITS;
  localparam int Q_W         = SCALED_W - SCALE_SHIFT;

  // Saturation limits.
  localparam logic [Q_W-1:0] Q_POS_MAX = Q_W'(32767);
  localparam logic [Q_W-1:0] Q_NEG_MAX = Q_W'(32768);
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MAX = 16'sh7fff;
  localparam logic signed [SAMPLE_W-1:0] SAMPLE_MIN = 16'sh8000;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PHASE_STEP  = 1'b0,
    CFG_OUTPUT_GAIN = 1'b1
  } srl_cfg_t;

  // Sequencer states.
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIFF,
    ST_ABS,
    ST_GAIN,
    ST_CLAMP,
    ST_SCALE,
    ST_OUT
  } srl_state_t;

  // Operation of the shared arithmetic unit in one cycle.
  typedef enum logic [2:0] {
    OP_NONE,
    OP_DIFF,
    OP_ABS,
    OP_GAIN,
    OP_CLAMP,
    OP_SCALE
  } srl_op_t;

  // Control from the sequencer to the datapath.
  typedef struct packed {
    srl_op_t op;
    logic    chan;
    logic    load_prev;
    logic    load_cur;
    logic    commit;
  } srl_ctrl_t;

endpackage

`default_nettype wire

// ===== design/stereo_linear_resampler_unit.sv =====
// Stereo linear-interpolation resampler: top level with configuration registers.
//
// Usage: one stereo input item (left_in, right_in) is taken on in_valid with
// in_stall low. The first item after reset only primes the sample history.
// Each later item yields zero to MAX_RUN result items on the output channel
// (left_out, right_out, last_of_run), in order; last_of_run marks the final
// result that the item causes.
// Operation: every result passes through the shared unit in five steps per
// channel through one multiplier, then waits in the output register until
// out_stall is low. An item holds the block until its last result has been
// taken; an item with no result is taken without starting the unit. in_stall
// is high from acceptance until the last result has been taken.
// A stall on the output holds the result and freezes the sequencer.
// Reset clears the phase, the primed flag and the sequencer, and loads
// phase_step = 83116 and output_gain = 256. Configuration writes through
// cfg_write, cfg_index and cfg_data take effect at once and belong to idle time.
`default_nettype none

module stereo_linear_resampler_unit import srl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_write,
  input  logic [CFG_IDX_W-1:0]       cfg_index,
  input  logic [CFG_DATA_W-1:0]      cfg_data,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] left_in,
  input  logic signed [SAMPLE_W-1:0] right_in,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [SAMPLE_W-1:0] left_out,
  output logic signed [SAMPLE_W-1:0] right_out,
  output logic                       last_of_run
);

  logic [STEP_W-1:0]          phase_step;
  logic [GAIN_W-1:0]          output_gain;
  logic [PHASE_FRAC_BITS-1:0] frac;
  srl_ctrl_t                  ctrl;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase_step  <= STEP_RESET;
      output_gain <= GAIN_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_PHASE_STEP:  phase_step  <= cfg_data[STEP_W-1:0];
        CFG_OUTPUT_GAIN: output_gain <= cfg_data[GAIN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  srl_sequencer u_seq (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .out_stall   (out_stall),
    .phase_step  (phase_step),
    .in_stall    (in_stall),
    .out_valid   (out_valid),
    .last_of_run (last_of_run),
    .frac        (frac),
    .ctrl        (ctrl)
  );

  srl_datapath u_dp (
    .clk       (clk),
    .ctrl      (ctrl),
    .left_in   (left_in),
    .right_in  (right_in),
    .frac      (frac),
    .gain      (output_gain),
    .left_res  (left_out),
    .right_res (right_out)
  );

`ifndef SYNTHESIS
  // No new item is taken while a result is offered.
  a_no_accept_while_out: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted while a result is pending");

  // A result is never offered directly after acceptance; the unit steps come first.
  a_no_instant_result: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> !out_valid)
    else $error("result offered right after acceptance");

  // Taking the last result of a run returns the block to idle.
  a_last_ends_run: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_stall && last_of_run) |=> (!out_valid && !in_stall))
    else $error("block not idle after the last result of a run");
`endif

endmodule

`default_nettype wire

// ===== design/srl_datapath.sv =====
// Sample registers and the shared multiply, magnitude, clamp and scale unit.
`default_nettype none

module srl_datapath import srl_pkg::*; (
  input  logic                       clk,
  input  srl_ctrl_t                  ctrl,
  input  logic signed [SAMPLE_W-1:0] left_in,
  input  logic signed [SAMPLE_W-1:0] right_in,
  input  logic [PHASE_FRAC_BITS-1:0] frac,
  input  logic [GAIN_W-1:0]          gain,
  output logic signed [SAMPLE_W-1:0] left_res,
  output logic signed [SAMPLE_W-1:0] right_res
);

  logic signed [SAMPLE_W-1:0] prev_left;
  logic signed [SAMPLE_W-1:0] prev_right;
  logic signed [SAMPLE_W-1:0] cur_left;
  logic signed [SAMPLE_W-1:0] cur_right;
  logic signed [PROD_W-1:0]   prod;
  logic [MAG_W-1:0]           mag;
  logic                       neg;
  logic [CAP_W-1:0]           gm;

  logic signed [SAMPLE_W-1:0] a_sel;
  logic signed [SAMPLE_W-1:0] b_sel;
  logic signed [DIFF_W-1:0]   diff;
  logic signed [MULA_W-1:0]   mul_a;
  logic signed [MULB_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]   mul_p;
  logic signed [IV_W-1:0]     a_ext;
  logic signed [IV_W-1:0]     iv;
  logic [MAG_W-1:0]           mag_calc;
  logic [PROD_W-2:0]          gp;
  logic [CAP_W-1:0]           gm_calc;
  logic [SCALED_W-1:0]        scaled;
  logic [Q_W-1:0]             q;
  logic signed [SAMPLE_W-1:0] sat;

  // Operands of the channel being worked on.
  always_comb begin
    a_sel = ctrl.chan ? prev_right : prev_left;
    b_sel = ctrl.chan ? cur_right : cur_left;
    diff  = {b_sel[SAMPLE_W-1], b_sel} - {a_sel[SAMPLE_W-1], a_sel};
  end

  // Shared multiplier: difference times phase, then magnitude times gain.
  always_comb begin
    case (ctrl.op)
      OP_DIFF: begin
        mul_a = MULA_W'(diff);
        mul_b = MULB_W'(frac);
      end
      OP_GAIN: begin
        mul_a = MULA_W'(mag);
        mul_b = MULB_W'(gain);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end
  assign mul_p = mul_a * mul_b;

  // Interpolated value and its magnitude.
  always_comb begin
    a_ext    = IV_W'(a_sel);
    iv       = (a_ext <<< PHASE_FRAC_BITS) + IV_W'(prod);
    mag_calc = iv[IV_W-1] ? MAG_W'(-iv) : MAG_W'(iv);
  end

  // Clamp of the gained magnitude.
  always_comb begin
    gp = prod[PROD_W-2:0];
    if (gp > {{(PROD_W-1-CAP_W){1'b0}}, MAG_CAP}) begin
      gm_calc = MAG_CAP;
    end else begin
      gm_calc = gp[CAP_W-1:0];
    end
  end

  // Scale by 32767/32768, truncate and saturate with the sign restored.
  always_comb begin
    scaled = {gm, {TRIM_BITS{1'b0}}} - SCALED_W'(gm);
    q      = scaled[SCALED_W-1:SCALE_SHIFT];
    if (neg) begin
      sat = (q > Q_NEG_MAX) ? SAMPLE_MIN : SAMPLE_W'(-q);
    end else begin
      sat = (q > Q_POS_MAX) ? SAMPLE_MAX : SAMPLE_W'(q);
    end
  end

  // Sample history.
  always_ff @(posedge clk) begin
    if (ctrl.load_prev) begin
      prev_left  <= left_in;
      prev_right <= right_in;
    end else if (ctrl.commit) begin
      prev_left  <= cur_left;
      prev_right <= cur_right;
    end
    if (ctrl.load_cur) begin
      cur_left  <= left_in;
      cur_right <= right_in;
    end
  end

  // Working registers of the shared unit.
  always_ff @(posedge clk) begin
    case (ctrl.op)
      OP_DIFF, OP_GAIN: begin
        prod <= mul_p;
      end
      OP_ABS: begin
        mag <= mag_calc;
        neg <= iv[IV_W-1];
      end
      OP_CLAMP: begin
        gm <= gm_calc;
      end
      OP_SCALE: begin
        if (ctrl.chan) begin
          right_res <= sat;
        end else begin
          left_res <= sat;
        end
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

// ===== design/srl_sequencer.sv =====
// Sequencer: phase accumulator, run counter and the per-result step order.
`default_nettype none

module srl_sequencer import srl_pkg::*; (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  input  logic                       out_stall,
  input  logic [STEP_W-1:0]          phase_step,
  output logic                       in_stall,
  output logic                       out_valid,
  output logic                       last_of_run,
  output logic [PHASE_FRAC_BITS-1:0] frac,
  output srl_ctrl_t                  ctrl
);

  srl_state_t         state;
  srl_state_t         state_next;
  logic               chan;
  logic               chan_next;
  logic [RUN_W-1:0]   run;
  logic [PHASE_W-1:0] phase_acc;
  logic               primed;
  logic               last;

  logic [PHASE_W-1:0] phase_sum;
  logic               below_one;
  logic               accept;
  logic               last_calc;
  logic               out_take;

  always_comb begin
    phase_sum = phase_acc + PHASE_W'(phase_step);
    below_one = phase_acc < PHASE_ONE;
    accept    = (state == ST_IDLE) && in_valid;
    last_calc = (phase_sum >= PHASE_ONE) || (run == RUN_LAST);
    out_take  = (state == ST_OUT) && !out_stall;
  end

  // Next state: five unit steps per channel, then the result is offered.
  always_comb begin
    state_next = state;
    chan_next  = chan;
    case (state)
      ST_IDLE: begin
        if (in_valid && primed && below_one) begin
          state_next = ST_DIFF;
          chan_next  = 1'b0;
        end
      end
      ST_DIFF:  state_next = ST_ABS;
      ST_ABS:   state_next = ST_GAIN;
      ST_GAIN:  state_next = ST_CLAMP;
      ST_CLAMP: state_next = ST_SCALE;
      ST_SCALE: begin
        if (chan) begin
          state_next = ST_OUT;
        end else begin
          state_next = ST_DIFF;
          chan_next  = 1'b1;
        end
      end
      ST_OUT: begin
        if (!out_stall) begin
          state_next = last ? ST_IDLE : ST_DIFF;
          chan_next  = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    in_stall       = (state != ST_IDLE);
    out_valid      = (state == ST_OUT);
    last_of_run    = last;
    frac           = phase_acc[PHASE_FRAC_BITS-1:0];
    ctrl.chan      = chan;
    ctrl.load_prev = accept && !(primed && below_one);
    ctrl.load_cur  = accept && primed && below_one;
    ctrl.commit    = out_take && last;
    case (state)
      ST_DIFF:  ctrl.op = OP_DIFF;
      ST_ABS:   ctrl.op = OP_ABS;
      ST_GAIN:  ctrl.op = OP_GAIN;
      ST_CLAMP: ctrl.op = OP_CLAMP;
      ST_SCALE: ctrl.op = OP_SCALE;
      default:  ctrl.op = OP_NONE;
    endcase
  end

  // State, phase and run bookkeeping.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      chan      <= 1'b0;
      run       <= '0;
      phase_acc <= '0;
      primed    <= 1'b0;
      last      <= 1'b0;
    end else begin
      state <= state_next;
      chan  <= chan_next;
      if (accept) begin
        primed <= 1'b1;
        run    <= '0;
        if (primed && !below_one) begin
          phase_acc <= phase_acc - PHASE_ONE;
        end
      end
      if ((state == ST_SCALE) && chan) begin
        last <= last_calc;
      end
      if (out_take) begin
        if (last) begin
          phase_acc <= (phase_sum >= PHASE_ONE) ? phase_sum - PHASE_ONE : '0;
        end else begin
          phase_acc <= phase_sum;
          run       <= run + RUN_W'(1);
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== sim/tb_stereo_linear_resampler_unit.sv =====
// Self-checking testbench for the stereo linear resampler unit.
module tb_stereo_linear_resampler_unit;
  import srl_pkg::*;

  localparam int CLK_HALF    = 10;
  localparam int MAX_WAIT    = 17;
  localparam int IDLE_LIMIT  = 2000;
  localparam int HOLD_CYCLES = 300;
  localparam int TAIL_CYCLES = 100;
  localparam int SEG_ITEMS   = 22;

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] left;
    logic signed [SAMPLE_W-1:0] right;
    logic                       last;
  } stereo_result_t;

  logic                       clk       = 1'b0;
  logic                       rst       = 1'b1;
  logic                       cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]       cfg_index = '0;
  logic [CFG_DATA_W-1:0]      cfg_data  = '0;
  logic                       in_valid  = 1'b0;
  logic signed [SAMPLE_W-1:0] left_in   = '0;
  logic signed [SAMPLE_W-1:0] right_in  = '0;
  logic                       out_stall = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic signed [SAMPLE_W-1:0] left_out;
  logic signed [SAMPLE_W-1:0] right_out;
  logic                       last_of_run;

  stereo_linear_resampler_unit dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_write  (cfg_write),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .left_in    (left_in),
    .right_in   (right_in),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .left_out   (left_out),
    .right_out  (right_out),
    .last_of_run(last_of_run)
  );

  // Shadow copy of the block's registers and history.
  longint                     shadow_step  = STEP_RESET;
  longint                     shadow_gain  = GAIN_RESET;
  logic signed [SAMPLE_W-1:0] hist_left    = '0;
  logic signed [SAMPLE_W-1:0] hist_right   = '0;
  longint                     shadow_phase = 0;
  bit                         hist_primed  = 1'b0;

  stereo_result_t pending_results[$];
  int             mismatch_count = 0;
  int             idle_cycles    = 0;
  int             hold_request   = 0;
  bit             tx_idle        = 1'b1;
  bit             rx_idle        = 1'b1;

  initial begin
    forever #CLK_HALF clk = ~clk;
  end

  // One channel: interpolate, apply the gain, scale by 32767/32768, saturate.
  function automatic logic signed [SAMPLE_W-1:0] blend_channel(longint a, longint b, longint p);
    longint iv;
    longint mag;
    longint q;
    longint cap;
    bit     neg;
    cap = longint'(1) << (24 + PHASE_FRAC_BITS);
    iv  = a * (longint'(1) << PHASE_FRAC_BITS) + (b - a) * p;
    neg = iv < 0;
    mag = neg ? -iv : iv;
    mag = mag * shadow_gain;
    if (mag > cap) begin
      mag = cap;
    end
    q = (mag * 32767) >> (23 + PHASE_FRAC_BITS);
    if (neg) begin
      return (q > 32768) ? SAMPLE_MIN : SAMPLE_W'(-q);
    end else begin
      return (q > 32767) ? SAMPLE_MAX : SAMPLE_W'(q);
    end
  endfunction

  // Work out the run of results that one accepted item causes.
  function automatic void predict_outputs(logic signed [SAMPLE_W-1:0] l,
                                          logic signed [SAMPLE_W-1:0] r);
    stereo_result_t run [MAX_RUN];
    longint         one_q;
    int             n;
    one_q = longint'(1) << PHASE_FRAC_BITS;
    n = 0;
    if (!hist_primed) begin
      hist_left   = l;
      hist_right  = r;
      hist_primed = 1'b1;
      return;
    end
    while (shadow_phase < one_q && n < MAX_RUN) begin
      run[n].left  = blend_channel(hist_left, l, shadow_phase);
      run[n].right = blend_channel(hist_right, r, shadow_phase);
      run[n].last  = 1'b0;
      n++;
      shadow_phase += shadow_step;
    end
    if (n > 0) begin
      run[n-1].last = 1'b1;
    end
    for (int i = 0; i < n; i++) begin
      pending_results = {pending_results, run[i]};
    end
    shadow_phase = (shadow_phase >= one_q) ? shadow_phase - one_q : 0;
    hist_left  = l;
    hist_right = r;
  endfunction

  // Compare every accepted result with the oldest expectation.
  always @(posedge clk) begin : check_result
    stereo_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result left=%0d right=%0d last=%0b",
                 $time, left_out, right_out, last_of_run);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (left_out !== want.left) begin
          $display("%0t: left_out expected %0d got %0d", $time, want.left, left_out);
          mismatch_count++;
        end
        if (right_out !== want.right) begin
          $display("%0t: right_out expected %0d got %0d", $time, want.right, right_out);
          mismatch_count++;
        end
        if (last_of_run !== want.last) begin
          $display("%0t: last_of_run expected %0b got %0b", $time, want.last, last_of_run);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog: end the run when nothing has been accepted for too long.
  always @(posedge clk) begin
    if (rst || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles + 1 >= IDLE_LIMIT) begin
      $display("FAIL stereo_linear_resampler_unit");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Receiver: random stall before each result while rx_idle is set, or one long hold-off on request.
  initial begin : receiver
    int wait_cycles;
    forever begin
      wait_cycles = rx_idle ? $urandom_range(0, MAX_WAIT) : 0;
      if (hold_request > 0) begin
        wait_cycles  = hold_request;
        hold_request = 0;
      end
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  // Offer one stereo item and record its expected results once accepted.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] l,
                             input logic signed [SAMPLE_W-1:0] r);
    int gap;
    gap = tx_idle ? $urandom_range(0, MAX_WAIT) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    left_in  <= l;
    right_in <= r;
    do @(posedge clk); while (in_stall);
    predict_outputs(l, r);
  endtask

  // Wait until every expected result has arrived and the block is idle.
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Write the phase step, then the output gain; only called while idle.
  task automatic set_config(input logic [CFG_DATA_W-1:0] step,
                            input logic [CFG_DATA_W-1:0] gain);
    cfg_write <= 1'b1;
    cfg_index <= CFG_PHASE_STEP;
    cfg_data  <= step;
    @(posedge clk);
    shadow_step = step[STEP_W-1:0];
    cfg_index <= CFG_OUTPUT_GAIN;
    cfg_data  <= gain;
    @(posedge clk);
    shadow_gain = gain[GAIN_W-1:0];
    cfg_write <= 1'b0;
  endtask

  // Mostly uniform samples, with full-scale and near-zero values mixed in.
  function automatic logic signed [SAMPLE_W-1:0] rand_sample();
    case ($urandom_range(0, 9))
      0:       return SAMPLE_MAX;
      1:       return SAMPLE_MIN;
      2:       return '0;
      3:       return -16'sd1;
      default: return SAMPLE_W'($urandom);
    endcase
  endfunction

  // Reset register values: the first item primes, later ones give 0 or 1 result.
  task automatic test_default_rate();
    send_sample(16'sd1200, -16'sd800);
    repeat (5) send_sample(rand_sample(), rand_sample());
    settle();
  endtask

  // Full-scale samples with the largest gain, zero gain and unity gain.
  task automatic test_field_extremes();
    set_config(19'd8192, 19'd65535);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(16'sd0, 16'sd0);
    send_sample(-16'sd1, 16'sd1);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    settle();
    set_config(19'd8192, 19'd0);
    send_sample(SAMPLE_MIN, SAMPLE_MAX);
    send_sample(16'sd12345, -16'sd12345);
    settle();
    set_config(19'd65536, 19'd256);
    send_sample(SAMPLE_MIN, SAMPLE_MIN);
    send_sample(SAMPLE_MAX, SAMPLE_MAX);
    send_sample(SAMPLE_MIN, SAMPLE_MIN);
    settle();
  endtask

  // Steps too small to reach one within a run: the run is cut and the phase floors.
  task automatic test_run_cap();
    set_config(19'd0, 19'd256);
    send_sample(16'sd1000, -16'sd1000);
    send_sample(-16'sd20000, 16'sd20000);
    send_sample(16'sd5, 16'sd5);
    settle();
    set_config(19'd4096, 19'd300);
    send_sample(SAMPLE_MAX, SAMPLE_MIN);
    send_sample(16'sd100, -16'sd100);
    settle();
  endtask

  // Random streams under several rate and gain settings.
  task automatic test_random_rates();
    logic [CFG_DATA_W-1:0] step;
    logic [CFG_DATA_W-1:0] gain;
    for (int seg = 0; seg < 6; seg++) begin
      case (seg)
        0: begin
          step = 19'd8192;
          gain = CFG_DATA_W'($urandom_range(0, 65535));
        end
        1: begin
          step = 19'd524287;
          gain = 19'd256;
        end
        2: begin
          step = CFG_DATA_W'($urandom_range(8192, 131071));
          gain = CFG_DATA_W'($urandom_range(128, 512));
        end
        3: begin
          step = 19'd65536;
          gain = 19'd256;
        end
        4: begin
          step = CFG_DATA_W'($urandom_range(8192, 524287));
          gain = CFG_DATA_W'($urandom_range(0, 65535));
        end
        default: begin
          step = CFG_DATA_W'($urandom_range(20000, 90000));
          gain = 19'd65535;
        end
      endcase
      // One segment runs with no idling on either side.
      tx_idle = (seg != 3);
      rx_idle = (seg != 3);
      set_config(step, gain);
      repeat (SEG_ITEMS) send_sample(rand_sample(), rand_sample());
      settle();
    end
    tx_idle = 1'b1;
    rx_idle = 1'b1;
  endtask

  // Long receiver hold-off while the sender keeps offering items.
  task automatic test_back_pressure();
    set_config(19'd8192, 19'd256);
    tx_idle = 1'b0;
    hold_request = HOLD_CYCLES;
    repeat (8) send_sample(rand_sample(), rand_sample());
    settle();
    tx_idle = 1'b1;
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    test_default_rate();
    test_field_extremes();
    test_run_cap();
    test_random_rates();
    test_back_pressure();
    settle();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("PASS stereo_linear_resampler_unit");
    end else begin
      $display("FAIL stereo_linear_resampler_unit");
    end
    $finish;
  end

endmodule
